// File: rtl/ntc_pkg.sv
package ntc_pkg;

	localparam int ADC_BITS_DEF = 12;

	// Register and port widths.
	localparam int PAD_W      = 20;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int TEMP_W     = 8;
	localparam int STAT_W     = 2;

	// Reset values of the configuration registers.
	localparam logic [COEF_W-1:0] COEF_A_RST = 32'd895287032;
	localparam logic [COEF_W-1:0] COEF_B_RST = 32'd232880337;
	localparam logic [COEF_W-1:0] COEF_C_RST = 32'd72974;
	localparam logic [PAD_W-1:0]  PAD_RST    = 20'd100000;

	// Base-2 logarithm: Q1.30 mantissa, one squaring per fraction bit.
	localparam int FRAC_W     = 30;
	localparam int MANT_W     = FRAC_W + 1;
	localparam int LOG_ROUNDS = FRAC_W;

	// ln(2) in Q.24 and the shift that brings the product back to Q.16.
	localparam int              LN2_W   = 24;
	localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
	localparam int              RND_SH  = 38;

	// Fraction bits dropped after each polynomial product.
	localparam int POLY_SH = 16;

	// Kelvin offset 273.15 = 5463 / 20; the polynomial is scaled by 2^40.
	localparam int               KC_NUM_W = 13;
	localparam int               KC_DEN_W = 5;
	localparam logic [KC_NUM_W-1:0] KC_NUM = 13'd5463;
	localparam logic [KC_DEN_W-1:0] KC_DEN = 5'd20;
	localparam int               COEF_FRAC = 40;

	// Quotient bits resolved by the divider (magnitudes up to 511).
	localparam int QB = 9;

	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 8'sd127;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -8'sd128;
	localparam logic [QB-1:0]            QPOS_MAX = 9'd127;
	localparam logic [QB-1:0]            QNEG_MAX = 9'd128;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A = 2'd0,
		REG_COEF_B = 2'd1,
		REG_COEF_C = 2'd2,
		REG_PAD    = 2'd3
	} cfg_reg_t;

	// Control that travels with each beat down the pipeline.
	typedef struct packed {
		logic vld;
		logic zero;
	} ntc_ctl_t;

endpackage

// File: rtl/ntc_ifs.sv
interface ntc_in_if #(parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntc_out_if;
	import ntc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_c;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output temperature_c, output status, input ready);
	modport sink   (input valid, input temperature_c, input status, output ready);
endinterface

interface ntc_cfg_if;
	import ntc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ntc_ln.sv
module ntc_ln #(
	parameter int XW = 36,
	parameter int LW = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [XW-1:0]     num_x,
	input  logic [XW-1:0]     den_x,
	input  ntc_pkg::ntc_ctl_t ctl_i,
	output logic [LW-1:0]     lmag,
	output logic              lneg,
	output ntc_pkg::ntc_ctl_t ctl_o
);
	import ntc_pkg::*;

	localparam int KW = $clog2(XW);
	localparam int YW = KW + FRAC_W;
	localparam int PW = YW + LN2_W;
	localparam logic [PW:0] RND_HALF = (PW+1)'(1) << (RND_SH - 1);

	function automatic logic [KW-1:0] msb_idx(input logic [XW-1:0] x);
		logic [KW-1:0] k;
		k = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				k = KW'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [MANT_W-1:0] norm(input logic [XW-1:0] x,
	                                            input logic [KW-1:0] k);
		logic [XW-1:0] xs;
		xs = x << (KW'(XW - 1) - k);
		return xs[XW-1 -: MANT_W];
	endfunction

	logic [MANT_W-1:0]   mn_s [0:LOG_ROUNDS];
	logic [MANT_W-1:0]   md_s [0:LOG_ROUNDS];
	logic [KW-1:0]       kn_s [0:LOG_ROUNDS];
	logic [KW-1:0]       kd_s [0:LOG_ROUNDS];
	logic [FRAC_W-1:0]   fn_s [0:LOG_ROUNDS];
	logic [FRAC_W-1:0]   fd_s [0:LOG_ROUNDS];
	ntc_ctl_t            ctl_s [0:LOG_ROUNDS];
	logic [2*MANT_W-1:0] pn_c [0:LOG_ROUNDS-1];
	logic [2*MANT_W-1:0] pd_c [0:LOG_ROUNDS-1];
	logic [MANT_W:0]     tn_c [0:LOG_ROUNDS-1];
	logic [MANT_W:0]     td_c [0:LOG_ROUNDS-1];

	logic [YW-1:0] yn, yd;
	logic [YW-1:0] dmag_s31;
	logic          lneg_s31, lneg_s32, lneg_s33;
	logic [PW-1:0] prod_s32;
	logic [LW-1:0] lmag_s33;
	ntc_ctl_t      ctl_s31, ctl_s32, ctl_s33;
	logic [PW:0]   rsum;

	// Each round squares the mantissa; a result of two or more yields a one bit.
	always_comb begin
		for (int r = 0; r < LOG_ROUNDS; r++) begin
			pn_c[r] = (2*MANT_W)'(mn_s[r]) * (2*MANT_W)'(mn_s[r]);
			pd_c[r] = (2*MANT_W)'(md_s[r]) * (2*MANT_W)'(md_s[r]);
			tn_c[r] = pn_c[r][FRAC_W +: MANT_W+1];
			td_c[r] = pd_c[r][FRAC_W +: MANT_W+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r <= LOG_ROUNDS; r++) begin
				ctl_s[r] <= '0;
			end
			ctl_s31 <= '0;
			ctl_s32 <= '0;
			ctl_s33 <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_i;
			for (int r = 0; r < LOG_ROUNDS; r++) begin
				ctl_s[r+1] <= ctl_s[r];
			end
			ctl_s31 <= ctl_s[LOG_ROUNDS];
			ctl_s32 <= ctl_s31;
			ctl_s33 <= ctl_s32;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kn_s[0] <= msb_idx(num_x);
			kd_s[0] <= msb_idx(den_x);
			mn_s[0] <= norm(num_x, msb_idx(num_x));
			md_s[0] <= norm(den_x, msb_idx(den_x));
			fn_s[0] <= '0;
			fd_s[0] <= '0;
			for (int r = 0; r < LOG_ROUNDS; r++) begin
				kn_s[r+1] <= kn_s[r];
				kd_s[r+1] <= kd_s[r];
				mn_s[r+1] <= tn_c[r][MANT_W] ? tn_c[r][MANT_W:1] : tn_c[r][MANT_W-1:0];
				md_s[r+1] <= td_c[r][MANT_W] ? td_c[r][MANT_W:1] : td_c[r][MANT_W-1:0];
				fn_s[r+1] <= fn_s[r] | (FRAC_W'(tn_c[r][MANT_W]) << (FRAC_W - 1 - r));
				fd_s[r+1] <= fd_s[r] | (FRAC_W'(td_c[r][MANT_W]) << (FRAC_W - 1 - r));
			end
		end
	end

	assign yn   = {kn_s[LOG_ROUNDS], fn_s[LOG_ROUNDS]};
	assign yd   = {kd_s[LOG_ROUNDS], fd_s[LOG_ROUNDS]};
	assign rsum = {1'b0, prod_s32} + RND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s31 <= yn < yd;
			dmag_s31 <= (yn < yd) ? (yd - yn) : (yn - yd);
			lneg_s32 <= lneg_s31;
			prod_s32 <= PW'(dmag_s31) * PW'(LN2_Q24);
			lneg_s33 <= lneg_s32;
			lmag_s33 <= LW'(rsum >> RND_SH);
		end
	end

	assign lmag  = lmag_s33;
	assign lneg  = lneg_s33;
	assign ctl_o = ctl_s33;

endmodule

// File: rtl/ntc_poly.sv
module ntc_poly #(
	parameter int LW = 23,
	parameter int SW = 55
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [LW-1:0]              lmag,
	input  logic                       lneg,
	input  ntc_pkg::ntc_ctl_t          ctl_i,
	input  logic [ntc_pkg::COEF_W-1:0] coef_a,
	input  logic [ntc_pkg::COEF_W-1:0] coef_b,
	input  logic [ntc_pkg::COEF_W-1:0] coef_c,
	output logic signed [SW-1:0]       s,
	output ntc_pkg::ntc_ctl_t          ctl_o
);
	import ntc_pkg::*;

	localparam int L2W = 2*LW - POLY_SH;
	localparam int L3W = 3*LW - 2*POLY_SH;
	localparam int TBW = COEF_W + LW - POLY_SH;
	localparam int TCW = COEF_W + L3W - POLY_SH;

	logic [2*LW-1:0]       sq_c;
	logic [COEF_W+LW-1:0]  bp_c;
	logic [L2W+LW-1:0]     cu_c;
	logic [COEF_W+L3W-1:0] cp_c;
	logic signed [SW-1:0]  sum_c;

	logic [LW-1:0]  lmag_s1;
	logic           lneg_s1, lneg_s2, lneg_s3;
	logic [L2W-1:0] l2_s1;
	logic [TBW-1:0] tb_s1, tb_s2, tb_s3;
	logic [L3W-1:0] l3_s2;
	logic [TCW-1:0] tc_s3;
	logic signed [SW-1:0] s_s4;
	ntc_ctl_t       ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	assign sq_c = (2*LW)'(lmag) * (2*LW)'(lmag);
	assign bp_c = (COEF_W+LW)'(coef_b) * (COEF_W+LW)'(lmag);
	assign cu_c = (L2W+LW)'(l2_s1) * (L2W+LW)'(lmag_s1);
	assign cp_c = (COEF_W+L3W)'(coef_c) * (COEF_W+L3W)'(l3_s2);

	// The log's sign sets whether both terms add to or come off the constant.
	always_comb begin
		if (lneg_s3) begin
			sum_c = $signed(SW'(coef_a)) - $signed(SW'(tb_s3)) - $signed(SW'(tc_s3));
		end else begin
			sum_c = $signed(SW'(coef_a)) + $signed(SW'(tb_s3)) + $signed(SW'(tc_s3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lmag_s1 <= lmag;
			lneg_s1 <= lneg;
			l2_s1   <= sq_c[2*LW-1:POLY_SH];
			tb_s1   <= bp_c[COEF_W+LW-1:POLY_SH];
			lneg_s2 <= lneg_s1;
			tb_s2   <= tb_s1;
			l3_s2   <= cu_c[L2W+LW-1:POLY_SH];
			lneg_s3 <= lneg_s2;
			tb_s3   <= tb_s2;
			tc_s3   <= cp_c[COEF_W+L3W-1:POLY_SH];
			s_s4    <= sum_c;
		end
	end

	assign s     = s_s4;
	assign ctl_o = ctl_s4;

endmodule

// File: rtl/ntc_div.sv
module ntc_div #(
	parameter int SW = 55
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic signed [SW-1:0]             s,
	input  ntc_pkg::ntc_ctl_t                ctl_i,
	output logic                             valid,
	output logic signed [ntc_pkg::TEMP_W-1:0] temperature_c,
	output logic [ntc_pkg::STAT_W-1:0]       status
);
	import ntc_pkg::*;

	localparam int NUMW = SW + KC_NUM_W + 1;
	localparam int DENW = SW + KC_DEN_W;
	localparam logic signed [NUMW-1:0] KNUM_S = NUMW'(KC_NUM);
	localparam logic signed [NUMW-1:0] KONE_S = NUMW'(KC_DEN) << COEF_FRAC;

	typedef struct packed {
		logic szero;
		logic sneg;
		logic nneg;
		logic ovf;
	} dflag_t;

	logic signed [NUMW-1:0] kp_s1, num_s2;
	logic [NUMW-1:0]        nmag_s3;
	logic [DENW-1:0]        den_s1, den_s2, den_s3;
	dflag_t                 fl_s1, fl_s2, fl_s3;
	ntc_ctl_t               ctl_s1, ctl_s2, ctl_s3, ctl_s14;

	// Restoring division, one quotient bit per stage, most significant first.
	logic [NUMW-1:0] r_s   [0:QB];
	logic [DENW-1:0] den_s [0:QB];
	logic [QB-1:0]   q_s   [0:QB];
	dflag_t          fl_s  [0:QB];
	ntc_ctl_t        ctl_s [0:QB];
	logic [NUMW-1:0] sub_c [0:QB-1];

	logic signed [TEMP_W-1:0] temp_c, temp_s14;
	logic [STAT_W-1:0]        stat_c, stat_s14;
	dflag_t                   fl_q;
	logic [QB-1:0]            qf;

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			sub_c[j] = NUMW'(den_s[j]) << (QB - 1 - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s14 <= '0;
			for (int j = 0; j <= QB; j++) begin
				ctl_s[j] <= '0;
			end
		end else if (en) begin
			ctl_s1   <= ctl_i;
			ctl_s2   <= ctl_s1;
			ctl_s3   <= ctl_s2;
			ctl_s[0] <= ctl_s3;
			for (int j = 0; j < QB; j++) begin
				ctl_s[j+1] <= ctl_s[j];
			end
			ctl_s14 <= ctl_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s1       <= NUMW'(s) * KNUM_S;
			den_s1      <= DENW'($unsigned(s)) * DENW'(KC_DEN);
			fl_s1.szero <= s == '0;
			fl_s1.sneg  <= s[SW-1];
			fl_s1.nneg  <= 1'b0;
			fl_s1.ovf   <= 1'b0;

			num_s2 <= KONE_S - kp_s1;
			den_s2 <= den_s1;
			fl_s2  <= fl_s1;

			nmag_s3 <= num_s2[NUMW-1] ? NUMW'(-num_s2) : NUMW'(num_s2);
			den_s3  <= den_s2;
			fl_s3   <= {fl_s2.szero, fl_s2.sneg, num_s2[NUMW-1], fl_s2.ovf};

			r_s[0]   <= nmag_s3;
			den_s[0] <= den_s3;
			q_s[0]   <= '0;
			fl_s[0]  <= {fl_s3.szero, fl_s3.sneg, fl_s3.nneg,
			             nmag_s3 >= (NUMW'(den_s3) << QB)};

			for (int j = 0; j < QB; j++) begin
				den_s[j+1] <= den_s[j];
				fl_s[j+1]  <= fl_s[j];
				if (r_s[j] >= sub_c[j]) begin
					r_s[j+1] <= r_s[j] - sub_c[j];
					q_s[j+1] <= q_s[j] | (QB'(1) << (QB - 1 - j));
				end else begin
					r_s[j+1] <= r_s[j];
					q_s[j+1] <= q_s[j];
				end
			end

			temp_s14 <= temp_c;
			stat_s14 <= stat_c;
		end
	end

	assign fl_q = fl_s[QB];
	assign qf   = q_s[QB];

	always_comb begin
		temp_c = TEMP_W'(qf);
		stat_c = ST_OK;
		if (ctl_s[QB].zero) begin
			temp_c = '0;
			stat_c = ST_ZERO;
		end else if (fl_q.szero) begin
			temp_c = TEMP_MAX;
			stat_c = ST_SAT;
		end else if (fl_q.sneg) begin
			temp_c = TEMP_MIN;
			stat_c = ST_SAT;
		end else if (!fl_q.nneg) begin
			if (fl_q.ovf || qf > QPOS_MAX) begin
				temp_c = TEMP_MAX;
				stat_c = ST_SAT;
			end
		end else begin
			if (fl_q.ovf || qf > QNEG_MAX) begin
				temp_c = TEMP_MIN;
				stat_c = ST_SAT;
			end else begin
				temp_c = $signed(~qf[TEMP_W-1:0] + TEMP_W'(1));
			end
		end
	end

	assign valid         = ctl_s14.vld;
	assign temperature_c = temp_s14;
	assign status        = stat_s14;

endmodule

// File: rtl/ntc_adc_to_temperature.sv
// NTC thermistor front end: each beat on adc carries one raw conversion of the
// thermistor/pad divider, and one beat on result returns the temperature in
// whole degrees Celsius, truncated toward zero and saturated to -128..127, with
// a status code (ok, zero resistance for a code or pad of zero, or saturated).
// The block is a fixed pipeline of 53 register stages: one input stage that
// forms pad*code and 2^ADC_BITS-code, 34 stages for the natural log (a
// normalize stage, 30 squaring stages that each yield one fraction bit of
// log2, then the difference, the scaling by ln 2 and the rounding), 4 stages
// for the Steinhart-Hart polynomial, and 14 stages for the Kelvin-to-Celsius
// division, which resolves one quotient bit per stage. A beat may enter on
// every clock while no result is held, a sustained rate of one item per cycle.
// The whole pipeline advances together: it moves whenever the output register
// is empty or being drained, so adc.ready follows result.ready when a result
// is waiting. The coefficient and pad registers are read by the stages that
// use them and are to be written only while no beat is in flight; the
// configuration channel is always ready.
module ntc_adc_to_temperature #(
	parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ntc_in_if.sink    adc,
	ntc_out_if.source result,
	ntc_cfg_if.sink   cfg
);
	import ntc_pkg::*;

	// Width of pad*code, and the log operand width (at least the mantissa).
	localparam int NW = PAD_W + ADC_BITS;
	localparam int XW = (NW > MANT_W) ? NW : MANT_W;
	localparam int KW = $clog2(XW);
	// ln(R) magnitude in Q.16, and the signed polynomial sum width.
	localparam int LW = KW + FRAC_W + LN2_W + 1 - RND_SH;
	localparam int SW = COEF_W + 3*LW - 3*POLY_SH + 2;

	logic [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic [PAD_W-1:0]  pad_q;

	logic          en;
	ntc_ctl_t      ctl_s1, ln_ctl, poly_ctl;
	logic [XW-1:0] num_s1, den_s1;
	logic [LW-1:0] lmag;
	logic          lneg;
	logic signed [SW-1:0] s;

	// Configuration registers; every index of the channel maps to a register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= COEF_A_RST;
			coef_b_q <= COEF_B_RST;
			coef_c_q <= COEF_C_RST;
			pad_q    <= PAD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_COEF_A: coef_a_q <= COEF_W'(cfg.data);
				REG_COEF_B: coef_b_q <= COEF_W'(cfg.data);
				REG_COEF_C: coef_c_q <= COEF_W'(cfg.data);
				REG_PAD:    pad_q    <= PAD_W'(cfg.data);
				default:    pad_q    <= pad_q;
			endcase
		end
	end

	// Global advance: every stage moves unless a finished result is held.
	assign en        = !result.valid || result.ready;
	assign adc.ready = en;

	// Input stage: divider resistance numerator and denominator. A zero
	// numerator (code zero or pad zero) is flagged and forces the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld  <= adc.valid;
			ctl_s1.zero <= (adc.adc_code == '0) || (pad_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= XW'(pad_q) * XW'(adc.adc_code);
			den_s1 <= XW'({1'b1, {ADC_BITS{1'b0}}} - {1'b0, adc.adc_code});
		end
	end

	ntc_ln #(
		.XW (XW),
		.LW (LW)
	) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num_x  (num_s1),
		.den_x  (den_s1),
		.ctl_i  (ctl_s1),
		.lmag   (lmag),
		.lneg   (lneg),
		.ctl_o  (ln_ctl)
	);

	ntc_poly #(
		.LW (LW),
		.SW (SW)
	) u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.lmag   (lmag),
		.lneg   (lneg),
		.ctl_i  (ln_ctl),
		.coef_a (coef_a_q),
		.coef_b (coef_b_q),
		.coef_c (coef_c_q),
		.s      (s),
		.ctl_o  (poly_ctl)
	);

	// The divider's last stage is the output register.
	ntc_div #(
		.SW (SW)
	) u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.s             (s),
		.ctl_i         (poly_ctl),
		.valid         (result.valid),
		.temperature_c (result.temperature_c),
		.status        (result.status)
	);

endmodule

// File: rtl/ntc_checker.sv
module ntc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              adc_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [ntc_pkg::TEMP_W-1:0] temperature_c,
	input logic [ntc_pkg::STAT_W-1:0]        status
);
	import ntc_pkg::*;

	// A held result stalls the whole pipeline, so no new beat is taken.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !adc_ready)
		else $error("input accepted while a result is held");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(temperature_c) && $stable(status))
		else $error("held result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_SAT))
		else $error("undefined status code");

	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_ZERO |-> temperature_c == '0)
		else $error("zero resistance with nonzero temperature");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SAT |-> (temperature_c == TEMP_MAX || temperature_c == TEMP_MIN))
		else $error("saturated result not at a rail");

endmodule

bind ntc_adc_to_temperature ntc_checker u_ntc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.adc_ready     (adc.ready),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.temperature_c (result.temperature_c),
	.status        (result.status)
);
